[rtl/core/segmented_prime_sieve_macros.svh]
// Assertion macros shared by the prime sieve RTL.
`ifndef SEGMENTED_PRIME_SIEVE_MACROS_SVH
`define SEGMENTED_PRIME_SIEVE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define SPS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sieve assertion failed");

// Next-cycle implication, sampled on clk, off during rst.
`define SPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sieve assertion failed");

`endif

[rtl/core/sps_pkg.sv]
// Shared constants and types of the segmented prime sieve.
package sps_pkg;

  localparam int VALUE_BITS_DEF = 20;
  localparam int BASE_LIMIT_DEF = 1024;
  localparam int WINDOW_DEF     = 128;
  localparam int MAX_RESULTS    = 32;

  // Row-wide commands to the window cells.
  typedef struct packed {
    logic init;   // set every flag to candidate
    logic shift;  // move every flag one cell toward cell 0
  } sps_row_ctl_t;

endpackage

[rtl/core/sps_if.sv]
// Query and result channel interfaces of the segmented prime sieve.
interface sps_query_if #(parameter int W = sps_pkg::VALUE_BITS_DEF);
  logic         valid;
  logic         ready;
  logic [W-1:0] low_bound;
  logic [W-1:0] high_bound;

  modport source (output valid, output low_bound, output high_bound, input ready);
  modport sink   (input valid, input low_bound, input high_bound, output ready);
endinterface

interface sps_result_if #(parameter int W = sps_pkg::VALUE_BITS_DEF);
  logic         valid;
  logic         ready;
  logic [W-1:0] prime_value;
  logic         found;
  logic         span_error;
  logic         last;

  modport source (output valid, output prime_value, output found, output span_error,
                  output last, input ready);
  modport sink   (input valid, input prime_value, input found, input span_error,
                  input last, output ready);
endinterface

[rtl/core/sps_cell.sv]
// One window cell: holds one candidate flag and passes the marking token on.
module sps_cell #(
  parameter int PW = 10,
  parameter int CW = PW + 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  sps_pkg::sps_row_ctl_t ctl,
  input  logic                  tok_v,
  input  logic [PW-1:0]         tok_p,
  input  logic [CW-1:0]         tok_cnt,
  input  logic                  flag_in,
  output logic                  tok_v_out,
  output logic [PW-1:0]         tok_p_out,
  output logic [CW-1:0]         tok_cnt_out,
  output logic                  flag
);
  import sps_pkg::*;

  logic hit;
  assign hit = tok_v && (tok_cnt == '0);

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      flag <= 1'b1;
    end else if (ctl.shift) begin
      flag <= flag_in;
    end else if (hit) begin
      flag <= 1'b0;
    end
  end

  // Reload the distance to the next multiple on a hit, else count down.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_v_out <= 1'b0;
    end else begin
      tok_v_out <= tok_v;
    end
    tok_p_out   <= tok_p;
    tok_cnt_out <= hit ? ({1'b0, tok_p} - CW'(1)) : (tok_cnt - CW'(1));
  end

endmodule

[rtl/core/sps_window.sv]
// Row of window cells; tokens travel up the row, flags shift down to cell 0.
module sps_window #(
  parameter int WINDOW = sps_pkg::WINDOW_DEF,
  parameter int PW     = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  sps_pkg::sps_row_ctl_t ctl,
  input  logic                  tok_v,
  input  logic [PW-1:0]         tok_p,
  input  logic [PW:0]           tok_cnt,
  output logic                  flag0
);
  import sps_pkg::*;

  logic          tv    [WINDOW+1];
  logic [PW-1:0] tp    [WINDOW+1];
  logic [PW:0]   tc    [WINDOW+1];
  logic          flags [WINDOW+1];

  assign tv[0]         = tok_v;
  assign tp[0]         = tok_p;
  assign tc[0]         = tok_cnt;
  assign flags[WINDOW] = 1'b0;
  assign flag0         = flags[0];

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    sps_cell #(.PW(PW), .CW(PW + 1)) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .tok_v       (tv[i]),
      .tok_p       (tp[i]),
      .tok_cnt     (tc[i]),
      .flag_in     (flags[i+1]),
      .tok_v_out   (tv[i+1]),
      .tok_p_out   (tp[i+1]),
      .tok_cnt_out (tc[i+1]),
      .flag        (flags[i])
    );
  end

endmodule

[rtl/core/sps_rem.sv]
// Bit-serial remainder unit: dividend mod divisor, one dividend bit a cycle.
module sps_rem #(
  parameter int VB = sps_pkg::VALUE_BITS_DEF,
  parameter int BL = 10
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [VB-1:0] dividend,
  input  logic [BL-1:0] divisor,
  output logic [BL-1:0] rem,
  output logic          done
);
  import sps_pkg::*;

  localparam int CNTW = $clog2(VB + 1);

  logic [CNTW-1:0] cnt;
  logic [VB-1:0]   dsh;
  logic [BL:0]     trial;

  assign trial = {rem, dsh[VB-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      cnt  <= CNTW'(VB);
      done <= 1'b0;
      rem  <= '0;
      dsh  <= dividend;
    end else begin
      done <= (cnt == CNTW'(1));
      if (cnt != '0) begin
        cnt <= cnt - CNTW'(1);
        dsh <= dsh << 1;
        rem <= (trial >= {1'b0, divisor}) ? BL'(trial - {1'b0, divisor}) : BL'(trial);
      end
    end
  end

endmodule

[rtl/core/segmented_prime_sieve.sv]
// Segmented prime sieve: lists every prime of one range per query, in order.
// A query beat carries low_bound and high_bound; low_bound below 2 is taken as 2.
// The block answers with one result beat per prime, ascending, with last on the
// final one (at most MAX_RESULTS primes). An empty range gives a single beat with
// found low and last high; a range longer than WINDOW numbers gives a single beat
// with span_error high. Queries are taken one at a time: query.ready is high only
// while the sequencer is idle, though the last result beat may still be waiting.
// Per query the block finds r = floor(sqrt(high_bound)) one bit at a time, clears
// and marks a base bitmap up to r, runs the remainder unit for each base prime,
// drains the window row, then scans span + 1 flags and sends the final beat; the
// scan and the final beat wait while the result side stalls.
// The base bitmap init and marking write one entry per cycle into a simple
// dual-port memory; the remainder unit works one dividend bit per cycle for each
// base prime. An empty or over-long range goes straight to the final beat.
// The window is a row of WINDOW cells: each base prime enters as a token with
// the distance to its first multiple, and every cell it passes clears its flag
// when the count hits zero, so marking of successive primes overlaps in the row.
// The flags then shift out through cell 0, one per cycle while the output is free.
`include "segmented_prime_sieve_macros.svh"

module segmented_prime_sieve #(
  parameter int VALUE_BITS = sps_pkg::VALUE_BITS_DEF,
  parameter int BASE_LIMIT = sps_pkg::BASE_LIMIT_DEF,
  parameter int WINDOW     = sps_pkg::WINDOW_DEF
) (
  input logic        clk,
  input logic        rst,
  sps_query_if.sink  query,
  sps_result_if.source result
);
  import sps_pkg::*;

  localparam int VB   = VALUE_BITS;
  localparam int BL   = $clog2(BASE_LIMIT);
  localparam int WI   = $clog2(WINDOW);
  localparam int RB   = (VB + 1) / 2;
  localparam int SBW  = (RB > 1) ? $clog2(RB) : 1;
  localparam int TW   = $clog2(MAX_RESULTS + 1);
  localparam int CMPW = (VB > BL + 1) ? VB : BL + 1;
  localparam int RMW  = (RB > BL) ? RB : BL;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SQRT  = 4'd1;
  localparam logic [3:0] S_BINIT = 4'd2;
  localparam logic [3:0] S_BRD   = 4'd3;
  localparam logic [3:0] S_BCHK  = 4'd4;
  localparam logic [3:0] S_BMARK = 4'd5;
  localparam logic [3:0] S_WRD   = 4'd6;
  localparam logic [3:0] S_WCHK  = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_INJ   = 4'd9;
  localparam logic [3:0] S_DRAIN = 4'd10;
  localparam logic [3:0] S_SCAN  = 4'd11;
  localparam logic [3:0] S_FIN   = 4'd12;

  logic [3:0]    state;
  logic [VB-1:0] low_r;
  logic [VB-1:0] high_r;
  logic [WI-1:0] lenm1;
  logic [RB-1:0] root;
  logic [SBW-1:0] sbit;
  logic [BL-1:0] r_lim;
  logic [BL:0]   bi;
  logic [BL-1:0] bp;
  logic [BL:0]   bm;
  logic [BL:0]   wp;
  logic [WI-1:0] idx;
  logic [TW-1:0] taken;
  logic          pend_v;
  logic [VB-1:0] pend;
  logic          err_r;

  // Output register.
  logic          ov;
  logic [VB-1:0] o_val;
  logic          o_found;
  logic          o_err;
  logic          o_last;

  // Base flag memory.
  logic          bmem [BASE_LIMIT];
  logic          b_we;
  logic [BL-1:0] b_wa;
  logic          b_wd;
  logic [BL-1:0] b_ra;
  logic          b_rd;

  always_ff @(posedge clk) begin
    if (b_we) begin
      bmem[b_wa] <= b_wd;
    end
    b_rd <= bmem[b_ra];
  end

  // Query decode.
  logic [VB-1:0] lowc;
  logic [VB-1:0] span;
  logic          q_empty;
  logic          q_long;

  assign lowc    = (query.low_bound < VB'(2)) ? VB'(2) : query.low_bound;
  assign span    = query.high_bound - lowc;
  assign q_empty = (query.high_bound < VB'(2)) || (lowc > query.high_bound);
  assign q_long  = (span >= VB'(WINDOW));

  // Square root trial bit.
  logic [RB-1:0]   sq_trial;
  logic [2*RB-1:0] sq_prod;
  logic            sq_fit;
  logic [RB-1:0]   root_fin;

  assign sq_trial = root | (RB'(1) << sbit);
  assign sq_prod  = (2*RB)'(sq_trial) * (2*RB)'(sq_trial);
  assign sq_fit   = (sq_prod <= (2*RB)'(high_r));
  assign root_fin = sq_fit ? sq_trial : root;

  logic [2*BL-1:0] bp_sq;
  assign bp_sq = (2*BL)'(bp) * (2*BL)'(bp);

  // Remainder unit.
  logic          div_start;
  logic          div_done;
  logic [BL-1:0] div_rem;

  sps_rem #(.VB(VB), .BL(BL)) u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (low_r),
    .divisor  (wp[BL-1:0]),
    .rem      (div_rem),
    .done     (div_done)
  );

  // Token start distance: offset of the first multiple at or above max(low, 2p).
  logic [BL-1:0] pw;
  logic          low_le_p;
  logic [BL:0]   tok_cnt;
  logic          tok_v;

  assign pw       = wp[BL-1:0];
  assign low_le_p = (CMPW'(low_r) <= CMPW'(pw));
  assign tok_cnt  = low_le_p ? ({pw, 1'b0} - (BL+1)'(low_r)) :
                    ((div_rem == '0) ? '0 : ({1'b0, pw} - {1'b0, div_rem}));
  assign tok_v    = (state == S_INJ);

  // Window row.
  sps_row_ctl_t row_ctl;
  logic         win_flag;
  logic         slot_free;

  assign slot_free = !ov || result.ready;

  sps_window #(.WINDOW(WINDOW), .PW(BL)) u_window (
    .clk     (clk),
    .rst     (rst),
    .ctl     (row_ctl),
    .tok_v   (tok_v),
    .tok_p   (pw),
    .tok_cnt (tok_cnt),
    .flag0   (win_flag)
  );

  // Combinational control.
  logic          emit;
  logic [VB-1:0] e_val;
  logic          e_found;
  logic          e_err;
  logic          e_last;

  always_comb begin
    b_we          = 1'b0;
    b_wa          = bi[BL-1:0];
    b_wd          = (bi >= (BL+1)'(2));
    b_ra          = (state == S_WRD) ? wp[BL-1:0] : bp;
    div_start     = (state == S_WCHK) && b_rd;
    row_ctl.init  = (state == S_BRD) && (bp_sq > (2*BL)'(r_lim));
    row_ctl.shift = (state == S_SCAN) && slot_free;
    emit          = 1'b0;
    e_val         = pend;
    e_found       = 1'b1;
    e_err         = 1'b0;
    e_last        = 1'b0;
    unique case (state)
      S_BINIT: begin
        b_we = 1'b1;
      end
      S_BMARK: begin
        b_we = (bm <= {1'b0, r_lim});
        b_wa = bm[BL-1:0];
        b_wd = 1'b0;
      end
      S_SCAN: begin
        emit = slot_free && win_flag && pend_v;
      end
      S_FIN: begin
        emit    = slot_free;
        e_last  = 1'b1;
        e_found = pend_v;
        e_val   = pend_v ? pend : '0;
        e_err   = pend_v ? 1'b0 : err_r;
      end
      default: begin
      end
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      pend_v <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (query.valid) begin
            pend_v <= 1'b0;
            taken  <= '0;
            low_r  <= lowc;
            high_r <= query.high_bound;
            lenm1  <= span[WI-1:0];
            root   <= '0;
            sbit   <= SBW'(RB - 1);
            err_r  <= !q_empty && q_long;
            state  <= (q_empty || q_long) ? S_FIN : S_SQRT;
          end
        end
        S_SQRT: begin
          root <= root_fin;
          if (sbit == '0) begin
            r_lim <= (RMW'(root_fin) >= RMW'(BASE_LIMIT - 1)) ? BL'(BASE_LIMIT - 1) :
                     BL'(root_fin);
            bi    <= '0;
            state <= S_BINIT;
          end else begin
            sbit <= sbit - SBW'(1);
          end
        end
        S_BINIT: begin
          if (bi == {1'b0, r_lim}) begin
            bp    <= BL'(2);
            state <= S_BRD;
          end else begin
            bi <= bi + (BL+1)'(1);
          end
        end
        S_BRD: begin
          if (bp_sq > (2*BL)'(r_lim)) begin
            wp    <= (BL+1)'(2);
            state <= S_WRD;
          end else begin
            state <= S_BCHK;
          end
        end
        S_BCHK: begin
          if (b_rd) begin
            bm    <= {bp, 1'b0};
            state <= S_BMARK;
          end else begin
            bp    <= bp + BL'(1);
            state <= S_BRD;
          end
        end
        S_BMARK: begin
          if (bm > {1'b0, r_lim}) begin
            bp    <= bp + BL'(1);
            state <= S_BRD;
          end else begin
            bm <= bm + {1'b0, bp};
          end
        end
        S_WRD: begin
          if (wp > {1'b0, r_lim}) begin
            idx   <= '0;
            state <= S_DRAIN;
          end else begin
            state <= S_WCHK;
          end
        end
        S_WCHK: begin
          if (b_rd) begin
            state <= S_DIV;
          end else begin
            wp    <= wp + (BL+1)'(1);
            state <= S_WRD;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_INJ;
          end
        end
        S_INJ: begin
          wp    <= wp + (BL+1)'(1);
          state <= S_WRD;
        end
        S_DRAIN: begin
          // Wait until the newest token has walked the whole row.
          if (idx == WI'(WINDOW - 1)) begin
            idx   <= '0;
            state <= S_SCAN;
          end else begin
            idx <= idx + WI'(1);
          end
        end
        S_SCAN: begin
          if (slot_free) begin
            if (win_flag) begin
              pend   <= low_r + VB'(idx);
              pend_v <= 1'b1;
              taken  <= taken + TW'(1);
            end
            if ((idx == lenm1) || (win_flag && (taken == TW'(MAX_RESULTS - 1)))) begin
              state <= S_FIN;
            end else begin
              idx <= idx + WI'(1);
            end
          end
        end
        S_FIN: begin
          if (slot_free) begin
            pend_v <= 1'b0;
            state  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register: hold a beat until taken, load a new one on emit.
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (emit) begin
      ov <= 1'b1;
    end else if (result.ready) begin
      ov <= 1'b0;
    end
    if (emit) begin
      o_val   <= e_val;
      o_found <= e_found;
      o_err   <= e_err;
      o_last  <= e_last;
    end
  end

  assign query.ready        = (state == S_IDLE);
  assign result.valid       = ov;
  assign result.prime_value = o_val;
  assign result.found       = o_found;
  assign result.span_error  = o_err;
  assign result.last        = o_last;

  `SPS_ASSERT_NOW(a_idle_no_pending, query.ready, !pend_v)
  `SPS_ASSERT_NEXT(a_fin_returns_idle, (state == S_FIN) && slot_free, state == S_IDLE)
  `SPS_ASSERT_NOW(a_rem_done_in_div, div_done, state == S_DIV)

endmodule

[dv/segmented_prime_sieve_tb.sv]
// Self-checking testbench of the segmented prime sieve: directed and random range queries.
module segmented_prime_sieve_tb;
  import sps_pkg::*;

  localparam int VB  = VALUE_BITS_DEF;
  localparam int WIN = WINDOW_DEF;
  localparam int STALL_LIMIT = 200000;

  typedef struct packed {
    logic [VB-1:0] prime_value;
    logic          found;
    logic          span_error;
    logic          last;
  } prime_beat_t;

  logic clk;
  logic rst;
  sps_query_if  #(.W(VB)) query_ch ();
  sps_result_if #(.W(VB)) result_ch ();

  segmented_prime_sieve u_top (
    .clk    (clk),
    .rst    (rst),
    .query  (query_ch.sink),
    .result (result_ch.source)
  );

  prime_beat_t expected_primes[$];
  int  error_count;
  int  idle_cycles;
  bit  no_idle;     // suppress random idling on both sides

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Compute the primes of one query, in order, and queue them as expected beats.
  task automatic predict_primes(input logic [VB-1:0] lo_in, input logic [VB-1:0] hi_in);
    int unsigned lo, hi, span, root, p, m;
    bit          composite[];
    int          count;
    prime_beat_t b;
    begin
      lo = (lo_in < 2) ? 2 : lo_in;
      hi = hi_in;
      count = 0;
      b = '0;
      if (hi < 2 || lo > hi) begin
        b.last = 1'b1;
        expected_primes.push_back(b);
      end else if (hi - lo + 1 > WIN) begin
        b.span_error = 1'b1;
        b.last = 1'b1;
        expected_primes.push_back(b);
      end else begin
        span = hi - lo + 1;
        composite = new[span];
        root = 0;
        while ((root + 1) * (root + 1) <= hi) root++;
        // Trial marking by every p up to the root gives the same set as marking by
        // primes only, since composite p have all their multiples covered already.
        for (p = 2; p <= root; p++) begin
          m = ((lo + p - 1) / p) * p;
          if (m < 2 * p) m = 2 * p;
          for (; m <= hi; m += p) composite[m - lo] = 1'b1;
        end
        for (int i = 0; i < span; i++) begin
          if (!composite[i] && count < MAX_RESULTS) begin
            b = '0;
            b.prime_value = VB'(lo + i);
            b.found = 1'b1;
            expected_primes.push_back(b);
            count++;
          end
        end
        if (count == 0) begin
          b = '0;
          b.last = 1'b1;
          expected_primes.push_back(b);
        end else begin
          expected_primes[expected_primes.size() - 1].last = 1'b1;
        end
      end
    end
  endtask

  // Send one query beat, with a random gap ahead of it, and hold it until taken.
  task automatic send_query(input int unsigned lo, input int unsigned hi);
    begin
      while (!no_idle && $urandom_range(99) < 29) @(posedge clk);
      predict_primes(VB'(lo), VB'(hi));
      query_ch.valid      <= 1'b1;
      query_ch.low_bound  <= VB'(lo);
      query_ch.high_bound <= VB'(hi);
      @(posedge clk);
      while (!query_ch.ready) @(posedge clk);
      query_ch.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Drain until every predicted beat has arrived.
  task automatic wait_drained();
    begin
      while (expected_primes.size() != 0) @(posedge clk);
    end
  endtask

  // Receiver: random backpressure, compare each beat with the oldest prediction.
  always @(posedge clk) begin
    prime_beat_t want;
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (expected_primes.size() == 0) begin
          $error("result beat with no query pending: value %0d", result_ch.prime_value);
          error_count++;
        end else begin
          want = expected_primes.pop_front();
          if (result_ch.prime_value !== want.prime_value) begin
            $error("prime_value: expected %0d got %0d", want.prime_value,
                   result_ch.prime_value);
            error_count++;
          end
          if (result_ch.found !== want.found) begin
            $error("found: expected %0d got %0d", want.found, result_ch.found);
            error_count++;
          end
          if (result_ch.span_error !== want.span_error) begin
            $error("span_error: expected %0d got %0d", want.span_error,
                   result_ch.span_error);
            error_count++;
          end
          if (result_ch.last !== want.last) begin
            $error("last: expected %0d got %0d", want.last, result_ch.last);
            error_count++;
          end
        end
      end
      result_ch.ready <= no_idle || ($urandom_range(99) >= 29);
    end
  end

  // Watchdog: count cycles with no beat moving on either channel.
  always @(posedge clk) begin
    if (rst || (query_ch.valid && query_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Field extremes, empty ranges, over-long spans and prime-free ranges.
  task automatic test_directed();
    begin
      send_query(0, 0);
      send_query(0, 1);
      send_query(1, 2);
      send_query(0, 127);
      send_query(0, 128);
      send_query(0, 129);
      send_query(20'hFFFFF, 20'hFFFFF);
      send_query(20'hFFFFF - 127, 20'hFFFFF);
      send_query(20'hFFFFF - 128, 20'hFFFFF);
      send_query(0, 20'hFFFFF);
      send_query(100, 50);
      send_query(24, 28);
      send_query(1327, 1361);
      send_query(97, 97);
      send_query(20'h55555, 20'h555D4);
      send_query(20'hAAAAA, 20'hAAB29);
      send_query(999900, 1000000);
      send_query(2, 2);
    end
  endtask

  // Idle the sender until the block has answered everything.
  task automatic test_drain_pause();
    begin
      send_query(500, 600);
      wait_drained();
      send_query(600, 700);
    end
  endtask

  // Random queries: mostly valid spans, some empty, some too long.
  task automatic test_random(input int n);
    int unsigned lo, hi, kind;
    begin
      for (int i = 0; i < n; i++) begin
        no_idle = (i >= n / 2 && i < n / 2 + 20);
        kind = $urandom_range(9);
        lo = $urandom_range(20'hFFFFF);
        if (kind < 2) lo = $urandom_range(200);
        if (kind < 7) begin
          hi = lo + $urandom_range(WIN - 1);
          if (hi > 20'hFFFFF) hi = 20'hFFFFF;
        end else if (kind < 9) begin
          hi = (lo > 0) ? $urandom_range(lo - 1) : 0;
        end else begin
          hi = (lo + WIN + $urandom_range(4000) > 20'hFFFFF) ? 20'hFFFFF
                : lo + WIN + $urandom_range(4000);
        end
        send_query(lo, hi);
      end
      no_idle = 1'b0;
    end
  endtask

  initial begin
    rst = 1'b1;
    error_count = 0;
    no_idle = 1'b0;
    query_ch.valid = 1'b0;
    query_ch.low_bound = '0;
    query_ch.high_bound = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_drain_pause();
    test_random(100);
    wait_drained();
    repeat (50) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
